// ===== hw/rtl/matrix3_inverse_assert.svh =====
// Assertion macros shared by the matrix inverse RTL.
`ifndef MATRIX3_INVERSE_ASSERT_SVH
`define MATRIX3_INVERSE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MI3_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MI3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mi3_pkg.sv =====
// Shared constants and types for the 3x3 matrix inverse.
package mi3_pkg;

   localparam int unsigned ELEM_WIDTH_DEF = 32;
   localparam int unsigned FRAC_BITS_DEF  = 16;
   localparam int unsigned N_DIM          = 3;
   localparam int unsigned N_ELEM         = 9;

   // Cofactor i is m[a]*m[b] - m[c]*m[d], with {a, b, c, d} per row below.
   localparam int unsigned CROSS_IDX [N_ELEM][4] = '{
      '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 4, 2},
      '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{2, 3, 0, 5},
      '{3, 7, 6, 4}, '{1, 6, 0, 7}, '{0, 4, 3, 1}
   };

   // Row-major position of the transposed element.
   localparam int unsigned TRANS_IDX [N_ELEM] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

   // Per-request side information that rides along with the divider.
   typedef struct packed {
      logic [N_ELEM-1:0] neg;
      logic              zero;
   } mi3_tag_type;

endpackage

// ===== hw/rtl/mi3_channels.sv =====
// Request, response and control register channel interfaces.
interface mi3_req_if #(
   parameter int unsigned ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [ELEM_WIDTH-1:0] row0_col0;
   logic signed [ELEM_WIDTH-1:0] row0_col1;
   logic signed [ELEM_WIDTH-1:0] row0_col2;
   logic signed [ELEM_WIDTH-1:0] row1_col0;
   logic signed [ELEM_WIDTH-1:0] row1_col1;
   logic signed [ELEM_WIDTH-1:0] row1_col2;
   logic signed [ELEM_WIDTH-1:0] row2_col0;
   logic signed [ELEM_WIDTH-1:0] row2_col1;
   logic signed [ELEM_WIDTH-1:0] row2_col2;

   modport source (
      output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
      output row2_col0, row2_col1, row2_col2,
      input  ready
   );
   modport sink (
      input  valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1, row1_col2,
      input  row2_col0, row2_col1, row2_col2,
      output ready
   );
endinterface

interface mi3_rsp_if #(
   parameter int unsigned ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [ELEM_WIDTH-1:0] out_r0c0;
   logic signed [ELEM_WIDTH-1:0] out_r0c1;
   logic signed [ELEM_WIDTH-1:0] out_r0c2;
   logic signed [ELEM_WIDTH-1:0] out_r1c0;
   logic signed [ELEM_WIDTH-1:0] out_r1c1;
   logic signed [ELEM_WIDTH-1:0] out_r1c2;
   logic signed [ELEM_WIDTH-1:0] out_r2c0;
   logic signed [ELEM_WIDTH-1:0] out_r2c1;
   logic signed [ELEM_WIDTH-1:0] out_r2c2;
   logic                         singular;
   logic                         saturated;

   modport source (
      output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
      output out_r2c0, out_r2c1, out_r2c2, singular, saturated,
      input  ready
   );
   modport sink (
      input  valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
      input  out_r2c0, out_r2c1, out_r2c2, singular, saturated,
      output ready
   );
endinterface

interface mi3_csr_if;
   logic valid;
   logic ready;
   logic transpose_output;

   modport source (output valid, transpose_output, input ready);
   modport sink (input valid, transpose_output, output ready);
endinterface

// ===== hw/rtl/matrix3_inverse.sv =====
// Pipelined 3x3 fixed-point matrix inverse (or inverse-transpose) top level.
//
// Usage: each request on req_ch carries a row-major 3x3 matrix of signed
// fixed-point elements (FRAC_BITS fraction bits). Each response on rsp_ch
// carries the nine elements of the inverse in the same format, plus the
// singular flag (zero determinant, all elements zero) and the saturated flag
// (some element was clamped to the signed range). Both channels move one
// request at a rising edge where valid and ready are high.
// Write transpose_output on csr_ch only while the block is idle; the block
// does not enforce it. 1 places the elements transposed; csr_ch never stalls.
// The pipeline has eight front-end stages for the cofactors, the determinant
// and the divider operands, ELEM_WIDTH+2 divider stages (an overflow check,
// then one quotient bit per stage) and the output register. One request is
// accepted per cycle unless every stage is full and rsp_ch is stalled.
// When rsp_ch is stalled the pipeline keeps every request; empty stages
// still fill, and req_ch.ready drops only once all stages hold a request.
// Reset clears all valid bits and transpose_output; no data is flushed.
`include "matrix3_inverse_assert.svh"

module matrix3_inverse #(
   parameter int unsigned ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
   parameter int unsigned FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   mi3_req_if.sink   req_ch,
   mi3_rsp_if.source rsp_ch,
   mi3_csr_if.sink   csr_ch
);

   localparam int unsigned W      = ELEM_WIDTH;
   localparam int unsigned NE     = mi3_pkg::N_ELEM;
   localparam int unsigned ND     = mi3_pkg::N_DIM;
   localparam int unsigned P_W    = 2 * W;
   localparam int unsigned ADJ_W  = 2 * W + 1;
   localparam int unsigned PP_W   = 2 * W + 1;
   localparam int unsigned DET_W  = 3 * W + 1;
   localparam int unsigned DM_W   = 3 * W;
   localparam int unsigned AM_W   = 2 * W;
   localparam int unsigned NM_W   = 2 * W + 2 * FRAC_BITS;
   localparam int unsigned Q_W    = W + 1;
   localparam int unsigned STEPS  = W + 2;

   // Stage numbers of the front end.
   localparam int unsigned ST_IN   = 0;
   localparam int unsigned ST_MUL  = 1;
   localparam int unsigned ST_ADJ  = 2;
   localparam int unsigned ST_PART = 3;
   localparam int unsigned ST_PROD = 4;
   localparam int unsigned ST_SUM  = 5;
   localparam int unsigned ST_DET  = 6;
   localparam int unsigned ST_MAG  = 7;
   localparam int unsigned FRONT   = ST_MAG + 1;
   localparam int unsigned NS      = FRONT + STEPS + 1;
   localparam int unsigned ST_OUT  = NS - 1;

   localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

   // Control register.
   logic tr_ff;
   logic tr_in;

   // Pipeline control.
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] adv;
   logic          in_take;
   logic          out_take;

   // Front-end payload.
   logic signed [W-1:0]     req_elem   [NE];
   logic signed [W-1:0]     elem_ff    [NE];
   logic signed [P_W-1:0]   s1_pa_ff   [NE];
   logic signed [P_W-1:0]   s1_pa_in   [NE];
   logic signed [P_W-1:0]   s1_pb_ff   [NE];
   logic signed [P_W-1:0]   s1_pb_in   [NE];
   logic signed [W-1:0]     s1_top_ff  [ND];
   logic signed [ADJ_W-1:0] s2_adj_ff  [NE];
   logic signed [ADJ_W-1:0] s2_adj_in  [NE];
   logic signed [W-1:0]     s2_top_ff  [ND];
   logic signed [PP_W-1:0]  s3_plo_ff  [ND];
   logic signed [PP_W-1:0]  s3_plo_in  [ND];
   logic signed [PP_W-1:0]  s3_phi_ff  [ND];
   logic signed [PP_W-1:0]  s3_phi_in  [ND];
   logic signed [ADJ_W-1:0] s3_adj_ff  [NE];
   logic signed [DET_W-1:0] s4_prod_ff [ND];
   logic signed [DET_W-1:0] s4_prod_in [ND];
   logic signed [ADJ_W-1:0] s4_adj_ff  [NE];
   logic signed [DET_W-1:0] s5_sum_ff;
   logic signed [DET_W-1:0] s5_p2_ff;
   logic signed [ADJ_W-1:0] s5_adj_ff  [NE];
   logic signed [DET_W-1:0] s6_det_ff;
   logic signed [ADJ_W-1:0] s6_adj_ff  [NE];
   logic [NM_W-1:0]         s7_num_ff  [NE];
   logic [NM_W-1:0]         s7_num_in  [NE];
   logic [DM_W-1:0]         s7_dmag_ff;
   logic [DM_W-1:0]         s7_dmag_in;
   mi3_pkg::mi3_tag_type    s7_tag_ff;
   mi3_pkg::mi3_tag_type    s7_tag_in;

   // Divider results and output stage.
   logic [Q_W-1:0]       div_quo [NE];
   logic [NE-1:0]        div_big;
   mi3_pkg::mi3_tag_type div_tag;
   logic [W-1:0]         out_elem_ff [NE];
   logic [W-1:0]         out_elem_in [NE];
   logic                 out_sing_ff;
   logic                 out_sing_in;
   logic                 out_sat_ff;
   logic                 out_sat_in;
   logic                 out_any_nz;

   // Control register write; the port never stalls.
   assign csr_ch.ready = 1'b1;
   assign tr_in        = csr_ch.valid ? csr_ch.transpose_output : tr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tr_ff <= 1'b0;
      end else begin
         tr_ff <= tr_in;
      end
   end

   // A stage advances when it or any stage after it is empty, or the output drains.
   for (genvar s = 0; s < NS; s++) begin : g_adv
      assign adv[s] = rsp_ch.ready | ~(&vld_ff[NS-1:s]);
   end

   assign in_take  = req_ch.valid & adv[ST_IN];
   assign out_take = vld_ff[ST_OUT] & rsp_ch.ready;

   always_comb begin
      vld_in[0] = adv[0] ? req_ch.valid : vld_ff[0];
      for (int s = 1; s < NS; s++) begin
         vld_in[s] = adv[s] ? vld_ff[s-1] : vld_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ch.ready = adv[ST_IN];

   // Request payload in row-major order.
   assign req_elem[0] = req_ch.row0_col0;
   assign req_elem[1] = req_ch.row0_col1;
   assign req_elem[2] = req_ch.row0_col2;
   assign req_elem[3] = req_ch.row1_col0;
   assign req_elem[4] = req_ch.row1_col1;
   assign req_elem[5] = req_ch.row1_col2;
   assign req_elem[6] = req_ch.row2_col0;
   assign req_elem[7] = req_ch.row2_col1;
   assign req_elem[8] = req_ch.row2_col2;

   // Eighteen element products for the nine cofactors.
   always_comb begin
      for (int i = 0; i < NE; i++) begin
         s1_pa_in[i] = elem_ff[mi3_pkg::CROSS_IDX[i][0]] * elem_ff[mi3_pkg::CROSS_IDX[i][1]];
         s1_pb_in[i] = elem_ff[mi3_pkg::CROSS_IDX[i][2]] * elem_ff[mi3_pkg::CROSS_IDX[i][3]];
      end
   end

   // Cofactors are exact differences of the product pairs.
   always_comb begin
      for (int i = 0; i < NE; i++) begin
         s2_adj_in[i] = s1_pa_ff[i] - s1_pb_ff[i];
      end
   end

   // Determinant terms m[t]*adj[3t], each split into two narrower partial products.
   always_comb begin
      logic signed [W:0] lo_s;
      logic signed [W:0] hi_s;
      for (int t = 0; t < ND; t++) begin
         lo_s         = $signed({1'b0, s2_adj_ff[t*ND][W-1:0]});
         hi_s         = $signed(s2_adj_ff[t*ND][ADJ_W-1:W]);
         s3_plo_in[t] = s2_top_ff[t] * lo_s;
         s3_phi_in[t] = s2_top_ff[t] * hi_s;
      end
   end

   // Recombine the partial products into full determinant terms.
   always_comb begin
      for (int t = 0; t < ND; t++) begin
         s4_prod_in[t] = (DET_W'(s3_phi_ff[t]) << W) + DET_W'(s3_plo_ff[t]);
      end
   end

   // Magnitudes and signs for the divider; numerator is |adj| scaled by 2^(2*FRAC_BITS).
   always_comb begin
      logic                    dneg;
      logic signed [DET_W-1:0] dabs;
      logic                    aneg;
      logic signed [ADJ_W-1:0] aabs;
      dneg           = s6_det_ff[DET_W-1];
      dabs           = dneg ? -s6_det_ff : s6_det_ff;
      s7_dmag_in     = dabs[DM_W-1:0];
      s7_tag_in.zero = (s6_det_ff == '0);
      for (int i = 0; i < NE; i++) begin
         aneg              = s6_adj_ff[i][ADJ_W-1];
         aabs              = aneg ? -s6_adj_ff[i] : s6_adj_ff[i];
         s7_num_in[i]      = NM_W'(aabs[AM_W-1:0]) << (2 * FRAC_BITS);
         s7_tag_in.neg[i]  = aneg ^ dneg;
      end
   end

   // Front-end stage registers.
   always_ff @(posedge clock) begin
      if (adv[ST_IN]) begin
         elem_ff <= req_elem;
      end
      if (adv[ST_MUL]) begin
         s1_pa_ff <= s1_pa_in;
         s1_pb_ff <= s1_pb_in;
         for (int t = 0; t < ND; t++) begin
            s1_top_ff[t] <= elem_ff[t];
         end
      end
      if (adv[ST_ADJ]) begin
         s2_adj_ff <= s2_adj_in;
         s2_top_ff <= s1_top_ff;
      end
      if (adv[ST_PART]) begin
         s3_plo_ff <= s3_plo_in;
         s3_phi_ff <= s3_phi_in;
         s3_adj_ff <= s2_adj_ff;
      end
      if (adv[ST_PROD]) begin
         s4_prod_ff <= s4_prod_in;
         s4_adj_ff  <= s3_adj_ff;
      end
      if (adv[ST_SUM]) begin
         s5_sum_ff <= s4_prod_ff[0] + s4_prod_ff[1];
         s5_p2_ff  <= s4_prod_ff[2];
         s5_adj_ff <= s4_adj_ff;
      end
      if (adv[ST_DET]) begin
         s6_det_ff <= s5_sum_ff + s5_p2_ff;
         s6_adj_ff <= s5_adj_ff;
      end
      if (adv[ST_MAG]) begin
         s7_num_ff  <= s7_num_in;
         s7_dmag_ff <= s7_dmag_in;
         s7_tag_ff  <= s7_tag_in;
      end
   end

   // Quotient magnitudes floor(num / |det|).
   mi3_divider #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .stage_en (adv[FRONT +: STEPS]),
      .in_dmag  (s7_dmag_ff),
      .in_num   (s7_num_ff),
      .in_tag   (s7_tag_ff),
      .out_quo  (div_quo),
      .out_big  (div_big),
      .out_tag  (div_tag)
   );

   // Sign, saturation, singular override and element placement.
   always_comb begin
      logic [Q_W-1:0] q;
      logic [Q_W-1:0] negq;
      logic           b;
      logic           n;
      logic           ovf;
      out_sat_in  = 1'b0;
      out_sing_in = div_tag.zero;
      for (int o = 0; o < NE; o++) begin
         q    = tr_ff ? div_quo[mi3_pkg::TRANS_IDX[o]] : div_quo[o];
         b    = tr_ff ? div_big[mi3_pkg::TRANS_IDX[o]] : div_big[o];
         n    = tr_ff ? div_tag.neg[mi3_pkg::TRANS_IDX[o]] : div_tag.neg[o];
         negq = ~q + Q_W'(1);
         if (n) begin
            ovf            = b | q[W] | (q[W-1] & (|q[W-2:0]));
            out_elem_in[o] = ovf ? MIN_NEG : negq[W-1:0];
         end else begin
            ovf            = b | q[W] | q[W-1];
            out_elem_in[o] = ovf ? MAX_POS : q[W-1:0];
         end
         if (div_tag.zero) begin
            out_elem_in[o] = '0;
         end else begin
            out_sat_in = out_sat_in | ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         out_elem_ff <= out_elem_in;
         out_sing_ff <= out_sing_in;
         out_sat_ff  <= out_sat_in;
      end
   end

   // Response channel.
   assign rsp_ch.valid     = vld_ff[ST_OUT];
   assign rsp_ch.out_r0c0  = out_elem_ff[0];
   assign rsp_ch.out_r0c1  = out_elem_ff[1];
   assign rsp_ch.out_r0c2  = out_elem_ff[2];
   assign rsp_ch.out_r1c0  = out_elem_ff[3];
   assign rsp_ch.out_r1c1  = out_elem_ff[4];
   assign rsp_ch.out_r1c2  = out_elem_ff[5];
   assign rsp_ch.out_r2c0  = out_elem_ff[6];
   assign rsp_ch.out_r2c1  = out_elem_ff[7];
   assign rsp_ch.out_r2c2  = out_elem_ff[8];
   assign rsp_ch.singular  = out_sing_ff;
   assign rsp_ch.saturated = out_sat_ff;

   // Any nonzero element in the output register.
   always_comb begin
      out_any_nz = 1'b0;
      for (int o = 0; o < NE; o++) begin
         out_any_nz = out_any_nz | (|out_elem_ff[o]);
      end
   end

   // The pipeline neither drops nor duplicates requests.
   `MI3_ASSERT_NEXT(a_occupancy, clock, reset, 1'b1, $countones(vld_ff) + $past(out_take) == $past($countones(vld_ff)) + $past(in_take), "pipeline occupancy does not match accepted and delivered requests")
   // An accepted request always lands in the input stage.
   `MI3_ASSERT_NEXT(a_in_lands, clock, reset, in_take, vld_ff[ST_IN], "accepted request missing from input stage")
   // A singular matrix never reports saturation.
   `MI3_ASSERT_SAME(a_flags_excl, clock, reset, rsp_ch.valid, !(rsp_ch.singular && rsp_ch.saturated), "singular and saturated both set")
   // A singular matrix gives all-zero elements.
   `MI3_ASSERT_SAME(a_sing_zero, clock, reset, rsp_ch.valid && rsp_ch.singular, !out_any_nz, "singular response with nonzero elements")

endmodule

// ===== hw/rtl/mi3_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, nine lanes sharing a divisor.
module mi3_divider #(
   parameter int unsigned ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
   parameter int unsigned FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic [ELEM_WIDTH+1:0]                stage_en,
   input  logic [3*ELEM_WIDTH-1:0]              in_dmag,
   input  logic [2*ELEM_WIDTH+2*FRAC_BITS-1:0]  in_num [mi3_pkg::N_ELEM],
   input  mi3_pkg::mi3_tag_type                 in_tag,
   output logic [ELEM_WIDTH:0]                  out_quo [mi3_pkg::N_ELEM],
   output logic [mi3_pkg::N_ELEM-1:0]           out_big,
   output mi3_pkg::mi3_tag_type                 out_tag
);

   localparam int unsigned DM_W  = 3 * ELEM_WIDTH;
   localparam int unsigned NM_W  = 2 * ELEM_WIDTH + 2 * FRAC_BITS;
   localparam int unsigned Q_W   = ELEM_WIDTH + 1;
   localparam int unsigned STEPS = ELEM_WIDTH + 2;
   localparam int unsigned SH_W  = DM_W + ELEM_WIDTH + 1;
   localparam int unsigned CW    = ((NM_W > SH_W) ? NM_W : SH_W) + 1;
   localparam int unsigned NL    = mi3_pkg::N_ELEM;

   logic [NM_W-1:0]      rem_ff  [STEPS][NL];
   logic [NM_W-1:0]      rem_in  [STEPS][NL];
   logic [Q_W-1:0]       quo_ff  [STEPS][NL];
   logic [Q_W-1:0]       quo_in  [STEPS][NL];
   logic [NL-1:0]        big_ff  [STEPS];
   logic [NL-1:0]        big_in  [STEPS];
   logic [DM_W-1:0]      dmag_ff [STEPS];
   logic [DM_W-1:0]      dmag_in [STEPS];
   mi3_pkg::mi3_tag_type tag_ff  [STEPS];
   mi3_pkg::mi3_tag_type tag_in  [STEPS];

   // Stage 0 only checks whether the quotient needs more than Q_W bits.
   // Each later stage decides one quotient bit, most significant first.
   always_comb begin
      logic [NM_W-1:0]      r_src;
      logic [Q_W-1:0]       q_src;
      logic                 b_src;
      logic [DM_W-1:0]      d_src;
      mi3_pkg::mi3_tag_type t_src;
      logic [CW-1:0]        d_sh;
      logic [CW-1:0]        diff;
      logic                 ge;
      int unsigned          shamt;
      for (int j = 0; j < STEPS; j++) begin
         if (j == 0) begin
            d_src = in_dmag;
            t_src = in_tag;
            shamt = ELEM_WIDTH + 1;
         end else begin
            d_src = dmag_ff[j-1];
            t_src = tag_ff[j-1];
            shamt = ELEM_WIDTH + 1 - j;
         end
         dmag_in[j] = d_src;
         tag_in[j]  = t_src;
         d_sh       = CW'(d_src) << shamt;
         for (int l = 0; l < NL; l++) begin
            if (j == 0) begin
               r_src = in_num[l];
               q_src = '0;
               b_src = 1'b0;
            end else begin
               r_src = rem_ff[j-1][l];
               q_src = quo_ff[j-1][l];
               b_src = big_ff[j-1][l];
            end
            diff = CW'(r_src) - d_sh;
            ge   = ~diff[CW-1];
            if (j == 0) begin
               rem_in[j][l] = r_src;
               quo_in[j][l] = q_src;
               big_in[j][l] = ge;
            end else begin
               rem_in[j][l] = ge ? diff[NM_W-1:0] : r_src;
               quo_in[j][l] = q_src | (Q_W'(ge) << shamt);
               big_in[j][l] = b_src;
            end
         end
      end
   end

   // Each stage holds while it and every later stage are full and the response is stalled.
   always_ff @(posedge clock) begin
      for (int j = 0; j < STEPS; j++) begin
         if (stage_en[j]) begin
            rem_ff[j]  <= rem_in[j];
            quo_ff[j]  <= quo_in[j];
            big_ff[j]  <= big_in[j];
            dmag_ff[j] <= dmag_in[j];
            tag_ff[j]  <= tag_in[j];
         end
      end
   end

   assign out_quo = quo_ff[STEPS-1];
   assign out_big = big_ff[STEPS-1];
   assign out_tag = tag_ff[STEPS-1];

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the pipelined 3x3 fixed-point matrix inverse.
module tb;

   localparam int unsigned EW          = mi3_pkg::ELEM_WIDTH_DEF;
   localparam int unsigned FB          = mi3_pkg::FRAC_BITS_DEF;
   localparam int unsigned LATENCY     = EW + 11;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int          ONE         = 1 << FB;

   typedef logic [EW-1:0]                      elem_type;
   typedef logic [mi3_pkg::N_ELEM-1:0][EW-1:0] matrix_type;

   typedef struct packed {
      logic [mi3_pkg::N_ELEM-1:0][EW-1:0] elem;
      logic                               singular;
      logic                               saturated;
   } inverse_type;

   typedef enum int unsigned {IDLE_NONE, IDLE_SOME, IDLE_HEAVY} idle_mode_type;

   localparam elem_type     ELEM_MIN = {1'b1, {(EW-1){1'b0}}};
   localparam elem_type     ELEM_MAX = ~ELEM_MIN;
   localparam logic [127:0] MAG_POS  = (128'd1 << (EW-1)) - 128'd1;
   localparam logic [127:0] MAG_NEG  = 128'd1 << (EW-1);

   logic clock;
   logic reset;

   mi3_req_if #(.ELEM_WIDTH(EW)) req_ch ();
   mi3_rsp_if #(.ELEM_WIDTH(EW)) rsp_ch ();
   mi3_csr_if                    csr_ch ();

   matrix3_inverse #(
      .ELEM_WIDTH(EW),
      .FRAC_BITS (FB)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // Expected inverses in request order, and the placement the block should use.
   inverse_type   pending_inverses[$];
   bit            transpose_reg = 1'b0;
   idle_mode_type req_mode = IDLE_SOME;
   idle_mode_type rsp_mode = IDLE_SOME;
   int            failures = 0;
   int unsigned   cycles = 0;
   int unsigned   n_checked = 0;
   int unsigned   n_singular = 0;
   int unsigned   n_saturated = 0;
   int unsigned   n_transposed = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Exact inverse: cofactors and determinant in wide integers, then a
   // truncating divide of each cofactor scaled by 2^(2*FB), with clamping.
   function automatic inverse_type predict_inverse(matrix_type m, bit transpose);
      logic signed [127:0] a [3][3];
      logic signed [127:0] adj [3][3];
      logic signed [127:0] det;
      logic [127:0]        det_mag;
      logic [127:0]        num;
      logic [127:0]        quot;
      elem_type            val;
      bit                  neg;
      inverse_type         res;
      res = '0;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            a[r][c] = signed'(m[r*3+c]);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            adj[r][c] = a[(c+1)%3][(r+1)%3] * a[(c+2)%3][(r+2)%3]
                      - a[(c+1)%3][(r+2)%3] * a[(c+2)%3][(r+1)%3];
      det = a[0][0] * adj[0][0] + a[0][1] * adj[1][0] + a[0][2] * adj[2][0];
      if (det == 0) begin
         res.singular = 1'b1;
         return res;
      end
      det_mag = (det < 0) ? -det : det;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            num  = (adj[r][c] < 0) ? -adj[r][c] : adj[r][c];
            num  = num << (2 * FB);
            quot = num / det_mag;
            neg  = (adj[r][c] < 0) != (det < 0);
            if (neg) begin
               if (quot > MAG_NEG) begin
                  val = ELEM_MIN;
                  res.saturated = 1'b1;
               end else begin
                  val = -quot[EW-1:0];
               end
            end else if (quot > MAG_POS) begin
               val = ELEM_MAX;
               res.saturated = 1'b1;
            end else begin
               val = quot[EW-1:0];
            end
            if (transpose) res.elem[c*3+r] = val;
            else res.elem[r*3+c] = val;
         end
      end
      return res;
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int unsigned pause_len(idle_mode_type mode);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (mode == IDLE_NONE) return 0;
      if (mode == IDLE_HEAVY) begin
         if (r < 40) return 0;
         if (r < 80) return $urandom_range(1, 8);
         return $urandom_range(40, 120);
      end
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int span(int unsigned lim);
      return int'($urandom_range(0, 2 * lim)) - int'(lim);
   endfunction

   function automatic elem_type pick_extreme();
      case ($urandom_range(0, 6))
         0: return ELEM_MIN;
         1: return ELEM_MAX;
         2: return '0;
         3: return elem_type'(1);
         4: return elem_type'(-1);
         5: return elem_type'(ONE);
         default: return elem_type'(-ONE);
      endcase
   endfunction

   function automatic matrix_type from_rows(elem_type a0, elem_type a1, elem_type a2,
                                            elem_type a3, elem_type a4, elem_type a5,
                                            elem_type a6, elem_type a7, elem_type a8);
      matrix_type m;
      m[0] = a0; m[1] = a1; m[2] = a2;
      m[3] = a3; m[4] = a4; m[5] = a5;
      m[6] = a6; m[7] = a7; m[8] = a8;
      return m;
   endfunction

   // Random matrix drawn from a mix of shapes that reach the different outcomes.
   function automatic matrix_type random_matrix();
      matrix_type  m;
      int unsigned kind;
      int unsigned s;
      int unsigned t;
      int unsigned j;
      int          k;
      m = '0;
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
         for (int i = 0; i < mi3_pkg::N_ELEM; i++) m[i] = $urandom();
      end else if (kind < 55) begin
         // Well conditioned: modest entries around a dominant diagonal.
         for (int i = 0; i < mi3_pkg::N_ELEM; i++) m[i] = span(4 * ONE);
         for (int r = 0; r < 3; r++)
            m[r*4] = signed'(m[r*4]) + ($urandom_range(0, 1) ? 12 * ONE : -12 * ONE);
      end else if (kind < 65) begin
         // Singular: one row or column is a multiple of another.
         for (int i = 0; i < mi3_pkg::N_ELEM; i++) m[i] = span(1 << 20);
         s = $urandom_range(0, 2);
         t = (s + 1 + $urandom_range(0, 1)) % 3;
         k = span(4);
         if ($urandom_range(0, 1))
            for (int c = 0; c < 3; c++) m[t*3+c] = k * signed'(m[s*3+c]);
         else
            for (int r = 0; r < 3; r++) m[r*3+t] = k * signed'(m[r*3+s]);
      end else if (kind < 75) begin
         for (int i = 0; i < mi3_pkg::N_ELEM; i++) m[i] = span(15);
      end else if (kind < 85) begin
         for (int i = 0; i < mi3_pkg::N_ELEM; i++)
            m[i] = signed'($urandom()) >>> $urandom_range(0, EW - 1);
      end else if (kind < 93) begin
         // Power-of-two diagonal gives exact results, with at most one
         // off-diagonal term.
         for (int r = 0; r < 3; r++)
            m[r*4] = ($urandom_range(0, 1) ? 1 : -1) * (1 << $urandom_range(0, 30));
         j = $urandom_range(0, mi3_pkg::N_ELEM - 1);
         if (j % 4 != 0) m[j] = span(ONE);
      end else begin
         for (int i = 0; i < mi3_pkg::N_ELEM; i++) m[i] = pick_extreme();
      end
      return m;
   endfunction

   task automatic drive_request(matrix_type m);
      req_ch.row0_col0 <= m[0];
      req_ch.row0_col1 <= m[1];
      req_ch.row0_col2 <= m[2];
      req_ch.row1_col0 <= m[3];
      req_ch.row1_col1 <= m[4];
      req_ch.row1_col2 <= m[5];
      req_ch.row2_col0 <= m[6];
      req_ch.row2_col1 <= m[7];
      req_ch.row2_col2 <= m[8];
   endtask

   // Send one request after an optional gap; record its expected inverse.
   task automatic send_matrix(matrix_type m);
      int unsigned n;
      n = pause_len(req_mode);
      if (n != 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      drive_request(m);
      do @(posedge clock); while (!req_ch.ready);
      pending_inverses.push_back(predict_inverse(m, transpose_reg));
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_inverses.size() != 0);
   endtask

   // Only called while no request is in flight.
   task automatic write_transpose(bit value);
      csr_ch.valid            <= 1'b1;
      csr_ch.transpose_output <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      transpose_reg = value;
   endtask

   task automatic run_random(int unsigned count);
      repeat (count) send_matrix(random_matrix());
   endtask

   // Field extremes, exact and clamped results, singular matrices; reset placement.
   task automatic test_edge_matrices();
      send_matrix(from_rows(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
      send_matrix('0);
      send_matrix(from_rows(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX,
                            ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX));
      send_matrix(from_rows(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN,
                            ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN));
      send_matrix(from_rows(ELEM_MIN, 0, 0, 0, ELEM_MIN, 0, 0, 0, ELEM_MIN));
      send_matrix(from_rows(ELEM_MAX, 0, 0, 0, ELEM_MAX, 0, 0, 0, ELEM_MAX));
      send_matrix(from_rows(1, 0, 0, 0, 1, 0, 0, 0, 1));
      send_matrix(from_rows(-1, 0, 0, 0, -1, 0, 0, 0, -1));
      // Reciprocal lands exactly on the most negative value, then one past the top.
      send_matrix(from_rows(-2, 0, 0, 0, ONE, 0, 0, 0, ONE));
      send_matrix(from_rows(2, 0, 0, 0, ONE, 0, 0, 0, ONE));
      send_matrix(from_rows(ONE, 2*ONE, 3*ONE, 0, ONE, 4*ONE, 0, 0, ONE));
      send_matrix(from_rows(0, ONE, 0, 0, 0, ONE, ONE, 0, 0));
      send_matrix(from_rows(2*ONE, -ONE, 0, -ONE, 2*ONE, -ONE, 0, -ONE, 2*ONE));
      // Thirds and sevenths check truncation toward zero on both signs.
      send_matrix(from_rows(ONE, 2*ONE, 0, 0, 3*ONE, 0, 0, 0, 7*ONE));
      send_matrix(from_rows(ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE,
                            7*ONE, 8*ONE, 9*ONE));
      send_matrix(from_rows(ONE, ELEM_MIN, 0, 0, ONE, 0, 0, 0, ONE));
      send_matrix(from_rows(ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MIN, ELEM_MAX,
                            ELEM_MIN, 1, -1, 0));
      send_matrix(from_rows({(EW/2){2'b01}}, {(EW/2){2'b10}}, 0,
                            {(EW/2){2'b10}}, 0, {(EW/2){2'b01}},
                            0, {(EW/2){2'b01}}, {(EW/2){2'b10}}));
      wait_drained();
   endtask

   // Non-symmetric matrices show whether elements land transposed.
   task automatic test_transpose_placement();
      write_transpose(1'b1);
      send_matrix(from_rows(ONE, 2*ONE, 3*ONE, 0, ONE, 4*ONE, 0, 0, ONE));
      send_matrix(from_rows(0, ONE, 0, 0, 0, ONE, ONE, 0, 0));
      send_matrix(from_rows(ONE, 2*ONE, 0, 0, 3*ONE, 0, 0, 0, 7*ONE));
      send_matrix(from_rows(ONE, ELEM_MIN, 0, 0, ONE, 0, 0, 0, ONE));
      send_matrix(from_rows(-2, ONE, 0, 0, ONE, 0, 0, 0, ONE));
      wait_drained();
   endtask

   task automatic test_random_mix();
      req_mode = IDLE_SOME;
      rsp_mode = IDLE_SOME;
      for (int phase = 0; phase < 2; phase++) begin
         write_transpose(phase[0]);
         run_random(250);
         wait_drained();
      end
   endtask

   // One request per cycle on both sides.
   task automatic test_full_rate();
      req_mode = IDLE_NONE;
      rsp_mode = IDLE_NONE;
      write_transpose(1'b1);
      run_random(300);
      wait_drained();
   endtask

   // Long response stalls fill the pipeline until the request side backs up.
   task automatic test_backpressure();
      req_mode = IDLE_NONE;
      rsp_mode = IDLE_HEAVY;
      write_transpose(1'b0);
      run_random(170);
      wait_drained();
      req_mode = IDLE_SOME;
      write_transpose(1'b1);
      run_random(170);
      wait_drained();
   endtask

   // Response side readiness.
   initial begin : rsp_ready_drive
      int unsigned n;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         n = pause_len(rsp_mode);
         if (n != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Compare each accepted response with the oldest expected inverse.
   always @(posedge clock) begin : check_responses
      inverse_type got;
      inverse_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.elem[0]   = rsp_ch.out_r0c0;
         got.elem[1]   = rsp_ch.out_r0c1;
         got.elem[2]   = rsp_ch.out_r0c2;
         got.elem[3]   = rsp_ch.out_r1c0;
         got.elem[4]   = rsp_ch.out_r1c1;
         got.elem[5]   = rsp_ch.out_r1c2;
         got.elem[6]   = rsp_ch.out_r2c0;
         got.elem[7]   = rsp_ch.out_r2c1;
         got.elem[8]   = rsp_ch.out_r2c2;
         got.singular  = rsp_ch.singular;
         got.saturated = rsp_ch.saturated;
         if (pending_inverses.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
         end else begin
            want = pending_inverses.pop_front();
            n_checked++;
            if (want.singular) n_singular++;
            if (want.saturated) n_saturated++;
            if (transpose_reg) n_transposed++;
            for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
               if (got.elem[i] !== want.elem[i]) begin
                  $error("%s mismatch: expected %0d, got %0d",
                         $sformatf("out_r%0dc%0d", i / 3, i % 3),
                         signed'(want.elem[i]), signed'(got.elem[i]));
                  failures++;
               end
            end
            if (got.singular !== want.singular) begin
               $error("singular mismatch: expected %0d, got %0d",
                      want.singular, got.singular);
               failures++;
            end
            if (got.saturated !== want.saturated) begin
               $error("saturated mismatch: expected %0d, got %0d",
                      want.saturated, got.saturated);
               failures++;
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin : main_sequence
      reset                   <= 1'b1;
      req_ch.valid            <= 1'b0;
      csr_ch.valid            <= 1'b0;
      csr_ch.transpose_output <= 1'b0;
      drive_request('0);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_edge_matrices();
      test_transpose_placement();
      test_random_mix();
      test_full_rate();
      test_backpressure();

      // Catch any stray response after the last expected one.
      repeat (2 * LATENCY) @(posedge clock);

      $display("Checked %0d inverses: %0d singular, %0d saturated, %0d transposed.",
               n_checked, n_singular, n_saturated, n_transposed);
      $display("Traffic ran with random gaps, at full rate, and under long stalls.");
      if (failures == 0 && pending_inverses.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
